// ===== sv/sbpo_pkg.sv =====
// ----------------------------------------------------------------------------
// sbpo_pkg
// Shared types and constants for the ball / convex polygon overlap test.
// ----------------------------------------------------------------------------
package sbpo_pkg;

	// default geometry
	localparam int MAX_CORNERS_DEF = 8;
	localparam int COORD_BITS_DEF  = 16;

	// input operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEST = 1'b1;

	// register reset value
	localparam logic [3:0] VERTEX_COUNT_RST = 4'd4;

	// operand select for the projection multipliers
	typedef enum logic [1:0] {
		SEL_VTX = 2'd0,
		SEL_LEN = 2'd1,
		SEL_CEN = 2'd2
	} mul_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic     wr_en;
		logic     ld_ball;
		logic     rd_en;
		logic     prj;
		logic     lat_p1;
		logic     ld_axis;
		logic     clr_ext;
		logic     cap_len;
		logic     ld_gap;
		logic     mul_start;
		mul_sel_t mul_sel;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic pipe_busy;
		logic gap_pos;
		logic mul_done;
		logic separated;
	} sts_t;

endpackage

// ===== sv/sbpo_mul.sv =====
// ----------------------------------------------------------------------------
// sbpo_mul
// Unsigned digit-serial multiplier: one 8-bit digit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
module sbpo_mul #(
	parameter int W = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [W-1:0]     a,
	input  logic [W-1:0]     b,
	output logic             busy,
	output logic [2*W-1:0]   p
);
	localparam int NDIG = (W + 7) / 8;
	localparam int BPW  = NDIG * 8;
	localparam int NW   = $clog2(NDIG + 1);

	logic [W-1:0]   a_q;
	logic [BPW-1:0] b_q;
	logic [2*W-1:0] acc_q;
	logic [NW-1:0]  cnt_q;
	logic           busy_q;
	logic [W+7:0]   part;

	// partial product of a and the top digit
	assign part = a_q * b_q[BPW-1 -: 8];

	// control: count digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= NW'(NDIG);
		end else if (busy_q) begin
			cnt_q <= cnt_q - NW'(1);
			if (cnt_q == NW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath: shift and accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= BPW'(b);
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= b_q << 8;
			acc_q <= (acc_q << 8) + (2*W)'(part);
		end
	end

	assign busy = busy_q;
	assign p    = acc_q;

endmodule

// ===== sv/sbpo_dp.sv =====
// ----------------------------------------------------------------------------
// sbpo_dp
// Datapath: corner tables, axis build, projection pipeline, gap and
// squared-distance compare.
// ----------------------------------------------------------------------------
module sbpo_dp #(
	parameter int MAX_CORNERS = sbpo_pkg::MAX_CORNERS_DEF,
	parameter int COORD_BITS  = sbpo_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sbpo_pkg::cmd_t                      cmd,
	input  logic [$clog2(MAX_CORNERS)-1:0]      rd_addr,
	input  logic [2:0]                          vertex_index,
	input  logic signed [COORD_BITS-1:0]        vertex_x,
	input  logic signed [COORD_BITS-1:0]        vertex_y,
	input  logic signed [COORD_BITS-1:0]        ball_x,
	input  logic signed [COORD_BITS-1:0]        ball_y,
	input  logic [9:0]                          ball_w,
	input  logic [9:0]                          ball_h,
	output sbpo_pkg::sts_t                      sts
);
	import sbpo_pkg::*;

	localparam int AW = $clog2(MAX_CORNERS);
	localparam int CB = COORD_BITS;
	localparam int OW = ((CB > 10) ? CB : 10) + 1;
	localparam int PW = 2 * OW;
	localparam int SW = PW + 1;
	localparam int MW = SW + 1;

	logic signed [CB-1:0] mem_x [MAX_CORNERS];
	logic signed [CB-1:0] mem_y [MAX_CORNERS];
	logic signed [CB-1:0] rdx_q, rdy_q, p1x_q, p1y_q;
	logic signed [OW-1:0] ax_q, ay_q, cx_q, cy_q;
	logic [17:0]          r2_q;
	logic [MW-1:0]        len2_q, g_q;
	logic                 gap_pos_q;
	logic signed [SW-1:0] lo_q, hi_q;
	logic                 first_q;
	logic                 rv_s1, pv_s2;
	logic signed [PW-1:0] prod1_s2, prod2_s2;

	logic [AW+2:0]        slot;
	logic signed [OW-1:0] op_a1, op_a2, op_b1, op_b2;
	logic signed [PW-1:0] prd1, prd2;
	logic signed [SW-1:0] sum;
	logic signed [MW-1:0] gh, gl;
	logic                 gh_pos, gl_pos;
	logic                 busy_g, busy_r;
	logic [2*MW-1:0]      gg, rl;

	assign slot = (AW+3)'(vertex_index);

	// corner tables: write on load, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en && (32'(slot) < MAX_CORNERS)) begin
			mem_x[slot[AW-1:0]] <= vertex_x;
			mem_y[slot[AW-1:0]] <= vertex_y;
		end
		if (cmd.rd_en) begin
			rdx_q <= mem_x[rd_addr];
			rdy_q <= mem_y[rd_addr];
		end
	end

	// ball center and squared radius, edge start point, axis
	always_ff @(posedge clk) begin
		if (cmd.ld_ball) begin
			cx_q <= OW'(ball_x) + $signed(OW'(ball_w[9:1]));
			cy_q <= OW'(ball_y) + $signed(OW'(ball_h[9:1]));
			r2_q <= ball_w[9:1] * ball_w[9:1];
		end
		if (cmd.lat_p1) begin
			p1x_q <= rdx_q;
			p1y_q <= rdy_q;
		end
		if (cmd.ld_axis) begin
			ax_q <= OW'(p1y_q) - OW'(rdy_q);
			ay_q <= OW'(rdx_q) - OW'(p1x_q);
		end
	end

	// select multiplier operands
	always_comb begin
		op_b1 = ax_q;
		op_b2 = ay_q;
		case (cmd.mul_sel)
			SEL_LEN: begin
				op_a1 = ax_q;
				op_a2 = ay_q;
			end
			SEL_CEN: begin
				op_a1 = cx_q;
				op_a2 = cy_q;
			end
			default: begin
				op_a1 = OW'(rdx_q);
				op_a2 = OW'(rdy_q);
			end
		endcase
	end

	assign prd1 = op_a1 * op_b1;
	assign prd2 = op_a2 * op_b2;
	assign sum  = SW'(prod1_s2) + SW'(prod2_s2);

	// projection pipeline: read, multiply, min/max
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
			pv_s2 <= 1'b0;
		end else begin
			rv_s1 <= cmd.rd_en && cmd.prj;
			pv_s2 <= rv_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod1_s2 <= prd1;
		prod2_s2 <= prd2;
		if (cmd.clr_ext) begin
			first_q <= 1'b1;
		end else if (pv_s2) begin
			first_q <= 1'b0;
			if (first_q || (sum < lo_q)) begin
				lo_q <= sum;
			end
			if (first_q || (sum > hi_q)) begin
				hi_q <= sum;
			end
		end
		if (cmd.cap_len) begin
			len2_q <= MW'(sum);
		end
	end

	// gaps between center projection and polygon extent
	assign gh     = MW'(sum) - MW'(hi_q);
	assign gl     = MW'(lo_q) - MW'(sum);
	assign gh_pos = !gh[MW-1] && (gh != '0);
	assign gl_pos = !gl[MW-1] && (gl != '0);

	always_ff @(posedge clk) begin
		if (cmd.ld_gap) begin
			gap_pos_q <= gh_pos || gl_pos;
			g_q       <= gh_pos ? gh : gl;
		end
	end

	// squared gap and squared radius times squared axis length
	sbpo_mul #(.W(MW)) u_mul_g (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (g_q),
		.b      (g_q),
		.busy   (busy_g),
		.p      (gg)
	);

	sbpo_mul #(.W(MW)) u_mul_r (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (MW'(r2_q)),
		.b      (len2_q),
		.busy   (busy_r),
		.p      (rl)
	);

	assign sts.pipe_busy = rv_s1 || pv_s2;
	assign sts.gap_pos   = gap_pos_q;
	assign sts.mul_done  = !busy_g && !busy_r;
	assign sts.separated = gg > rl;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |=> (busy_g && busy_r))
		else $error("multipliers not running after start");

	a_no_ext_during_len: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_gap |-> !(rv_s1 || pv_s2))
		else $error("gap taken while projections in flight");

	a_mul_pair: assert property (@(posedge clk) disable iff (!arst_n)
		busy_g == busy_r)
		else $error("multipliers out of step");

endmodule

// ===== sv/sbpo_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbpo_ctrl
// Controller: input and output handshake, vertex count register, axis and
// vertex sequencing.
// ----------------------------------------------------------------------------
module sbpo_ctrl #(
	parameter int MAX_CORNERS = sbpo_pkg::MAX_CORNERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            operation,
	input  logic                            cfg_write,
	input  logic [3:0]                      cfg_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            collided,
	output sbpo_pkg::cmd_t                  cmd,
	output logic [$clog2(MAX_CORNERS)-1:0]  rd_addr,
	input  sbpo_pkg::sts_t                  sts
);
	import sbpo_pkg::*;

	localparam int AW = $clog2(MAX_CORNERS);
	localparam int CW = $clog2(MAX_CORNERS + 1);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_RD_I  = 12'b0000_0000_0010,
		S_RD_J  = 12'b0000_0000_0100,
		S_EDGE  = 12'b0000_0000_1000,
		S_LEN   = 12'b0000_0001_0000,
		S_PROJ  = 12'b0000_0010_0000,
		S_DRAIN = 12'b0000_0100_0000,
		S_CEN   = 12'b0000_1000_0000,
		S_GAP   = 12'b0001_0000_0000,
		S_CHK   = 12'b0010_0000_0000,
		S_MUL   = 12'b0100_0000_0000,
		S_DONE  = 12'b1000_0000_0000
	} state_t;

	state_t        state_q, state_d;
	logic [3:0]    count_q;
	logic [CW-1:0] n_q, n_d, i_q, i_d, k_q, k_d, n_sat, i_inc, k_inc;
	logic          res_q, res_d;
	logic          out_valid_q, collided_q, out_load;

	assign n_sat = (32'(count_q) > MAX_CORNERS) ? CW'(MAX_CORNERS) : CW'(count_q);
	assign i_inc = i_q + CW'(1);
	assign k_inc = k_q + CW'(1);

	// next state and commands
	always_comb begin
		state_d     = state_q;
		n_d         = n_q;
		i_d         = i_q;
		k_d         = k_q;
		res_d       = res_q;
		out_load    = 1'b0;
		cmd         = '0;
		cmd.mul_sel = SEL_VTX;
		rd_addr     = i_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (operation == OP_LOAD) begin
						cmd.wr_en = 1'b1;
						res_d     = 1'b0;
						state_d   = S_DONE;
					end else begin
						cmd.ld_ball = 1'b1;
						n_d         = n_sat;
						i_d         = '0;
						if (n_sat == '0) begin
							res_d   = 1'b1;
							state_d = S_DONE;
						end else begin
							state_d = S_RD_I;
						end
					end
				end
			end
			S_RD_I: begin
				cmd.rd_en = 1'b1;
				state_d   = S_RD_J;
			end
			S_RD_J: begin
				cmd.rd_en  = 1'b1;
				cmd.lat_p1 = 1'b1;
				rd_addr    = (i_inc == n_q) ? '0 : i_inc[AW-1:0];
				state_d    = S_EDGE;
			end
			S_EDGE: begin
				cmd.ld_axis = 1'b1;
				state_d     = S_LEN;
			end
			S_LEN: begin
				cmd.mul_sel = SEL_LEN;
				cmd.clr_ext = 1'b1;
				k_d         = '0;
				state_d     = S_PROJ;
			end
			S_PROJ: begin
				cmd.rd_en   = 1'b1;
				cmd.prj     = 1'b1;
				cmd.cap_len = (k_q == '0);
				rd_addr     = k_q[AW-1:0];
				k_d         = k_inc;
				if (k_inc == n_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = S_CEN;
				end
			end
			S_CEN: begin
				cmd.mul_sel = SEL_CEN;
				state_d     = S_GAP;
			end
			S_GAP: begin
				cmd.ld_gap = 1'b1;
				state_d    = S_CHK;
			end
			S_CHK: begin
				if (sts.gap_pos) begin
					cmd.mul_start = 1'b1;
					state_d       = S_MUL;
				end else if (i_inc == n_q) begin
					res_d   = 1'b1;
					state_d = S_DONE;
				end else begin
					i_d     = i_inc;
					state_d = S_RD_I;
				end
			end
			S_MUL: begin
				if (sts.mul_done) begin
					if (sts.separated) begin
						res_d   = 1'b0;
						state_d = S_DONE;
					end else if (i_inc == n_q) begin
						res_d   = 1'b1;
						state_d = S_DONE;
					end else begin
						i_d     = i_inc;
						state_d = S_RD_I;
					end
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= VERTEX_COUNT_RST;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			i_q         <= '0;
			k_q         <= '0;
			res_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			i_q     <= i_d;
			k_q     <= k_d;
			res_q   <= res_d;
			if (cfg_write) begin
				count_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result beat
	always_ff @(posedge clk) begin
		if (out_load) begin
			collided_q <= res_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign collided  = collided_q;

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_DONE) |-> (i_q < n_q))
		else $error("axis index beyond vertex count");

	a_proj_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROJ) |-> (k_q < n_q))
		else $error("vertex index beyond vertex count");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> (state_q == S_DONE))
		else $error("result dropped while output stalled");

endmodule

// ===== sv/sat_ball_polygon_overlap.sv =====
// ----------------------------------------------------------------------------
// sat_ball_polygon_overlap
// Separating-axis overlap test of a ball against a convex polygon.
//
//   channel | valid     | stall      | beat
//   --------+-----------+------------+-------------------------------------
//   input   | in_valid  | in_stall   | operation, vertex_*, ball_*
//   output  | out_valid | out_stall  | collided
//   config  | cfg_write | -          | cfg_data (vertex_count)
//
// A test runs the serial squaring unit for each axis where the ball lies
// outside the polygon extent.
// One item is worked at a time; the next is taken while a result waits.
// Reset clears control only; corner tables hold no reset value.
// ----------------------------------------------------------------------------
module sat_ball_polygon_overlap #(
	parameter int MAX_CORNERS = sbpo_pkg::MAX_CORNERS_DEF,
	parameter int COORD_BITS  = sbpo_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [2:0]                    vertex_index,
	input  logic signed [COORD_BITS-1:0]  vertex_x,
	input  logic signed [COORD_BITS-1:0]  vertex_y,
	input  logic signed [COORD_BITS-1:0]  ball_x,
	input  logic signed [COORD_BITS-1:0]  ball_y,
	input  logic [9:0]                    ball_w,
	input  logic [9:0]                    ball_h,
	input  logic                          cfg_write,
	input  logic [3:0]                    cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          collided
);
	import sbpo_pkg::*;

	cmd_t                           cmd;
	sts_t                           sts;
	logic [$clog2(MAX_CORNERS)-1:0] rd_addr;

	// sequencer
	sbpo_ctrl #(.MAX_CORNERS(MAX_CORNERS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.collided  (collided),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.sts       (sts)
	);

	// arithmetic and tables
	sbpo_dp #(.MAX_CORNERS(MAX_CORNERS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rd_addr      (rd_addr),
		.vertex_index (vertex_index),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.ball_x       (ball_x),
		.ball_y       (ball_y),
		.ball_w       (ball_w),
		.ball_h       (ball_h),
		.sts          (sts)
	);

endmodule

// ===== verif/tb_sat_ball_polygon_overlap.sv =====
// ----------------------------------------------------------------------------
// tb_sat_ball_polygon_overlap
// Self-checking bench for the ball / convex polygon overlap test. Vertices
// are loaded and balls tested under random stalls and gaps on both channels.
// An in-bench model predicts each result, and the scoreboard compares it
// against the collided flag in arrival order.
// ----------------------------------------------------------------------------
module tb_sat_ball_polygon_overlap;
	timeunit 1ns;
	timeprecision 1ps;

	import sbpo_pkg::*;

	localparam int NCORN = MAX_CORNERS_DEF;
	localparam int CBITS = COORD_BITS_DEF;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic operation = OP_LOAD;
	logic [2:0] vertex_index = '0;
	logic signed [CBITS-1:0] vertex_x = '0;
	logic signed [CBITS-1:0] vertex_y = '0;
	logic signed [CBITS-1:0] ball_x = '0;
	logic signed [CBITS-1:0] ball_y = '0;
	logic [9:0] ball_w = '0;
	logic [9:0] ball_h = '0;
	logic cfg_write = 1'b0;
	logic [3:0] cfg_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic collided;

	sat_ball_polygon_overlap u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .vertex_index(vertex_index),
		.vertex_x(vertex_x), .vertex_y(vertex_y),
		.ball_x(ball_x), .ball_y(ball_y), .ball_w(ball_w), .ball_h(ball_h),
		.cfg_write(cfg_write), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall), .collided(collided)
	);

	always #4 clk = ~clk;

	// predictor state
	logic signed [CBITS-1:0] poly_x [NCORN];
	logic signed [CBITS-1:0] poly_y [NCORN];
	logic [3:0] model_count = VERTEX_COUNT_RST;
	bit expected_hits [$];
	int mismatches = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit stall_enable = 1'b1;

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// exact separating-axis test with squared comparison
	function automatic bit predict_hit(longint cx, longint cy, longint r);
		int n, j;
		longint ax, ay, p, lo, hi, c, len2, g;
		n = (model_count > NCORN) ? NCORN : model_count;
		for (int i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			ax = -(longint'(poly_y[j]) - longint'(poly_y[i]));
			ay = longint'(poly_x[j]) - longint'(poly_x[i]);
			len2 = ax * ax + ay * ay;
			lo = 0;
			hi = 0;
			for (int k = 0; k < n; k++) begin
				p = longint'(poly_x[k]) * ax + longint'(poly_y[k]) * ay;
				if (k == 0 || p < lo) lo = p;
				if (k == 0 || p > hi) hi = p;
			end
			c = cx * ax + cy * ay;
			g = c - hi;
			if (g > 0 && 128'(g) * 128'(g) > 128'(r * r) * 128'(len2)) return 1'b0;
			g = lo - c;
			if (g > 0 && 128'(g) * 128'(g) > 128'(r * r) * 128'(len2)) return 1'b0;
		end
		return 1'b1;
	endfunction

	// send one beat after an optional gap, hold until accepted, then predict
	task automatic send_beat(logic op, logic [2:0] idx, logic [15:0] vx, logic [15:0] vy,
			logic [15:0] bx, logic [15:0] by, logic [9:0] w, logic [9:0] h);
		longint cx, cy;
		int gap;
		gap = rand_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation <= op;
		vertex_index <= idx;
		vertex_x <= vx;
		vertex_y <= vy;
		ball_x <= bx;
		ball_y <= by;
		ball_w <= w;
		ball_h <= h;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (op == OP_LOAD) begin
			poly_x[idx] = vx;
			poly_y[idx] = vy;
			expected_hits = {expected_hits, 1'b0};
		end else begin
			cx = longint'($signed(bx)) + longint'(w >> 1);
			cy = longint'($signed(by)) + longint'(h >> 1);
			expected_hits = {expected_hits, predict_hit(cx, cy, longint'(w >> 1))};
		end
		@(negedge clk);
	endtask

	task automatic load_corner(int idx, int vx, int vy);
		send_beat(OP_LOAD, idx[2:0], vx[15:0], vy[15:0], 16'($urandom), 16'($urandom),
			10'($urandom), 10'($urandom));
	endtask

	task automatic test_ball(int bx, int by, int w, int h);
		send_beat(OP_TEST, 3'($urandom), 16'($urandom), 16'($urandom), bx[15:0], by[15:0],
			w[9:0], h[9:0]);
	endtask

	// drop valid, wait for all results, let the block settle, then write the count
	task automatic set_count(logic [3:0] n);
		in_valid <= 1'b0;
		while (expected_hits.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_data <= n;
		cfg_write <= 1'b1;
		@(negedge clk);
		cfg_write <= 1'b0;
		model_count = n;
	endtask

	task automatic load_polygon(int n, int cx, int cy, int rad);
		for (int i = 0; i < n; i++)
			load_corner(i, cx + ((i % 4 < 2) ? rad : -rad) + i,
				cy + ((i % 4 == 0 || i % 4 == 3) ? rad : -rad) - i);
	endtask

	// directed: square, extremes, degenerate counts and zero-length axes
	task automatic test_directed();
		load_corner(0, 100, 100);
		load_corner(1, -100, 100);
		load_corner(2, -100, -100);
		load_corner(3, 100, -100);
		test_ball(0, 0, 10, 10);
		test_ball(200, 0, 20, 20);
		test_ball(105, -5, 10, 10);
		test_ball(-32768, -32768, 0, 0);
		test_ball(32767, 32767, 1023, 1023);
		test_ball(-200, -200, 1023, 1023);
		set_count(4'd3);
		test_ball(90, -90, 4, 4);
		set_count(4'd15);
		load_corner(4, 32767, -32768);
		load_corner(5, -32768, 32767);
		load_corner(6, 32767, 32767);
		load_corner(7, -32768, -32768);
		test_ball(0, 0, 2, 2);
		test_ball(-32768, 32767, 1023, 0);
		set_count(4'd0);
		test_ball(5, 5, 4, 4);
		set_count(4'd1);
		test_ball(100, 100, 0, 0);
		test_ball(3000, 3000, 6, 6);
		set_count(4'd2);
		load_corner(1, 100, 100);
		test_ball(100, 100, 2, 2);
		test_ball(-500, 400, 8, 8);
	endtask

	// random: mostly fresh polygons then balls near them, some noise
	task automatic test_random();
		int n, cx, cy, rad, big;
		for (int round = 0; round < 50; round++) begin
			n = $urandom_range(3, 8);
			big = int'($urandom_range(0, 9) == 0);
			set_count((round % 9 == 0) ? 4'($urandom_range(0, 15)) : 4'(n));
			cx = $signed(16'($urandom_range(0, 65535))) / 2;
			cy = $signed(16'($urandom_range(0, 65535))) / 2;
			rad = big ? $urandom_range(1000, 16000) : $urandom_range(1, 500);
			if (round % 5 == 4)
				for (int i = 0; i < NCORN; i++)
					load_corner(i, $signed(16'($urandom)), $signed(16'($urandom)));
			else
				load_polygon(NCORN, cx, cy, rad);
			for (int t = 0; t < 4; t++) begin
				if ($urandom_range(0, 5) == 0)
					test_ball($signed(16'($urandom)), $signed(16'($urandom)),
						$urandom_range(0, 1023), $urandom_range(0, 1023));
				else
					test_ball(cx - rad - 600 + $urandom_range(0, 2 * rad + 1200),
						cy - rad - 600 + $urandom_range(0, 2 * rad + 1200),
						$urandom_range(0, 1023), $urandom_range(0, 1023));
			end
		end
	endtask

	// output side: random stall runs, mostly short and a few long
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_enable && ($urandom_range(0, 99) < 25)) begin
			out_stall <= 1'b1;
			stall_left <= rand_gap();
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each result beat
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result collided=%0b", collided);
			end else begin
				if (collided !== expected_hits[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("collided mismatch: expected %0b actual %0b",
							expected_hits[0], collided);
				end
				void'(expected_hits.pop_front());
			end
		end
	end

	// watchdog on handshakes
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NCORN; i++) begin
			poly_x[i] = '0;
			poly_y[i] = '0;
		end
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		test_directed();
		test_random();
		in_valid <= 1'b0;
		while (expected_hits.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (mismatches == 0 && expected_hits.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
